@@ rtl/tdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpc_pkg
// Shared types and constants of the trial-division prime counter.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  // fixed widths of the words on the channels
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // primality tester sequencer
  typedef enum logic [1:0] {
    TST_IDLE,
    TST_CHECK,
    TST_WAIT,
    TST_REPORT
  } tst_state_t;

  // divider status back to the tester
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

  // tester verdict back to the top level
  typedef struct packed {
    logic done;
    logic prime;
  } tst_res_t;

endpackage

@@ rtl/tdpc_if.sv @@
// ----------------------------------------------------------------------------
// tdpc_if
// Valid/ready channels of the prime counter: input word and result word.
// ----------------------------------------------------------------------------
interface tdpc_in_if import tdpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_in_run;

  modport source (output valid, output value, output last_in_run, input ready);
  modport sink   (input valid, input value, input last_in_run, output ready);
endinterface

interface tdpc_out_if import tdpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] prime_count;

  modport source (output valid, output prime_count, input ready);
  modport sink   (input valid, input prime_count, output ready);
endinterface

@@ rtl/trial_division_prime_counter_core.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_counter_core
// Counts primes in runs of signed words and gives the count on the last word.
// ----------------------------------------------------------------------------
// One input word is worked on at a time. The low VALUE_BITS bits of value are
// read as a two's complement number; negative values, zero and one are
// reported as not prime without a division. Any other n is tested with
// divisors 2, 3, ... while d*d <= n, each divisor going through the
// bit-serial remainder unit, and testing stops at the first divisor that
// leaves no remainder.
// The count saturates at all ones and is cleared after each run's last word.
// The result word sits in an output register, so the next input word is
// taken while a count still waits to be read.
module trial_division_prime_counter_core import tdpc_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  tdpc_in_if.sink   item,
  tdpc_out_if.source result
);

  // control of the current word
  logic busy;
  logic last_l;
  logic pend;
  logic pend_prime;
  logic accept;
  logic commit;

  // run count and result register
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               out_valid;
  logic [COUNT_W-1:0] out_data;

  tst_res_t tst_res;

  assign item.ready = !busy;
  assign accept     = item.valid && !busy;

  // a finished last word waits only if the result register is still full
  assign commit = pend && (!last_l || !out_valid || result.ready);

  // saturating count including the word just tested
  assign count_next = (pend_prime && count != COUNT_MAX) ? count + COUNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
      end

      if (tst_res.done) begin
        pend <= 1'b1;
      end else if (commit) begin
        pend <= 1'b0;
      end

      if (commit) begin
        count <= last_l ? '0 : count_next;
      end

      if (commit && last_l) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_l <= item.last_in_run;
    end
    if (tst_res.done) begin
      pend_prime <= tst_res.prime;
    end
    if (commit && last_l) begin
      out_data <= count_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.prime_count = out_data;

  tdpc_tester #(
    .VALUE_BITS (VALUE_BITS)
  ) u_tester (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .value (item.value[VALUE_BITS-1:0]),
    .res   (tst_res)
  );

  // tester only reports for a word in flight that has not yet reported
  a_report_in_flight: assert property (@(posedge clk) disable iff (rst)
    tst_res.done |-> busy && !pend)
    else $error("tester verdict without a word in flight");

  // saturated count holds through the rest of the run
  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    commit && !last_l && count == COUNT_MAX |=> count == COUNT_MAX)
    else $error("run count wrapped");

  // a result appears only after a last word is committed
  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(commit && last_l))
    else $error("result word without a finished last word");

  // an accepted word is held until its verdict comes back
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !pend)
    else $error("accepted word not held in flight");

endmodule

@@ rtl/tdpc_divider.sv @@
// ----------------------------------------------------------------------------
// tdpc_divider
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdpc_divider import tdpc_pkg::*; #(
  parameter int unsigned N_BITS = 31,
  parameter int unsigned D_BITS = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [N_BITS-1:0] dividend,
  input  logic [D_BITS-1:0] divisor,
  output div_stat_t         stat
);

  localparam int unsigned CNT_BITS = $clog2(N_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic                done;
  logic [N_BITS-1:0]   shreg;
  logic [D_BITS-1:0]   rem;
  logic [D_BITS-1:0]   dvs;

  logic [D_BITS:0]     trial;
  logic [D_BITS:0]     diff;
  logic [D_BITS-1:0]   rem_next;

  // shift in the next dividend bit, subtract when it fits
  assign trial    = {rem, shreg[N_BITS-1]};
  assign diff     = trial - {1'b0, dvs};
  assign rem_next = (trial >= {1'b0, dvs}) ? diff[D_BITS-1:0] : trial[D_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(N_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (cnt != '0) begin
      shreg <= {shreg[N_BITS-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

@@ rtl/tdpc_tester.sv @@
// ----------------------------------------------------------------------------
// tdpc_tester
// Trial-division sequencer: steps divisors while d*d <= n over the divider.
// ----------------------------------------------------------------------------
module tdpc_tester import tdpc_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output tst_res_t              res
);

  localparam int unsigned N_BITS = VALUE_BITS - 1;
  localparam int unsigned D_BITS = VALUE_BITS / 2 + 1;

  tst_state_t state, state_next;

  logic [N_BITS-1:0]     n;
  logic [D_BITS-1:0]     d;
  logic [VALUE_BITS-1:0] sq;
  logic                  prime;

  logic      trivial;
  logic      sq_over;
  logic      div_start;
  div_stat_t div_stat;

  // negative, zero and one are never prime
  assign trivial = value[VALUE_BITS-1] || (value[N_BITS-1:0] < N_BITS'(2));
  assign sq_over = (sq > {1'b0, n});

  always_comb begin
    state_next = state;
    unique case (state)
      TST_IDLE:   if (start) state_next = trivial ? TST_REPORT : TST_CHECK;
      TST_CHECK:  state_next = sq_over ? TST_REPORT : TST_WAIT;
      TST_WAIT:   if (div_stat.done) state_next = div_stat.rem_zero ? TST_REPORT : TST_CHECK;
      TST_REPORT: state_next = TST_IDLE;
      default:    state_next = TST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    res.done  = 1'b0;
    unique case (state)
      TST_CHECK:  div_start = !sq_over;
      TST_REPORT: res.done  = 1'b1;
      default:    ;
    endcase
  end

  assign res.prime = prime;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == TST_IDLE && start) begin
      n     <= value[N_BITS-1:0];
      d     <= D_BITS'(2);
      sq    <= VALUE_BITS'(4);
      prime <= 1'b0;
    end else if (state == TST_CHECK && sq_over) begin
      prime <= 1'b1;
    end else if (state == TST_WAIT && div_stat.done && !div_stat.rem_zero) begin
      // (d+1)^2 = d^2 + 2d + 1
      d  <= d + D_BITS'(1);
      sq <= sq + VALUE_BITS'({d, 1'b1});
    end
  end

  tdpc_divider #(
    .N_BITS (N_BITS),
    .D_BITS (D_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .stat     (div_stat)
  );

endmodule
